@@ rtl/bdc_pkg.sv @@
// Package for the button debounce and combo detector: constants, codes, types, key table.
package bdc_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int TIME_BITS_DEF   = 32;
  localparam int MAX_COMBOS      = 4;
  localparam int NUM_PAIRS       = 4;
  localparam int COMBO_LIM       = (MAX_COMBOS < NUM_PAIRS) ? MAX_COMBOS : NUM_PAIRS;

  localparam int NOW_W      = 32;
  localparam int LEVEL_W    = 6;
  localparam int BTN_IDX_W  = 3;
  localparam int NUM_IDX    = 8;
  localparam int EVENT_W    = 3;
  localparam int SLOT_W     = 2;
  localparam int KEY_W      = 8;
  localparam int MS_W       = 16;
  localparam int COUNT_W    = 3;
  localparam int PAIR_W     = 6;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [MS_W-1:0]    DEBOUNCE_RST = MS_W'(20);
  localparam logic [MS_W-1:0]    WINDOW_RST   = MS_W'(500);
  localparam logic [COUNT_W-1:0] COUNT_RST    = '0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEBOUNCE   = 4'd0,
    REG_WINDOW     = 4'd1,
    REG_COUNT      = 4'd2,
    REG_PAIR0      = 4'd3,
    REG_PAIR1      = 4'd4,
    REG_PAIR2      = 4'd5,
    REG_PAIR3      = 4'd6,
    REG_KEY_ENABLE = 4'd7
  } cfg_reg_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_COMBO   = 3'd2,
    EV_KEY     = 3'd3,
    EV_RELEASE = 3'd4
  } event_t;

  typedef struct packed {
    logic [MS_W-1:0]                   settle_ms;
    logic [MS_W-1:0]                   combo_window_ms;
    logic [COUNT_W-1:0]                combo_count;
    logic [NUM_PAIRS-1:0][PAIR_W-1:0]  combo_pair;
    logic                              key_event_enable;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic                 load;  // latch a new scan
    logic                 step;  // process button idx, load result register
    logic [BTN_IDX_W-1:0] idx;
  } dp_cmd_t;

  function automatic logic [KEY_W-1:0] key_of(input logic [BTN_IDX_W-1:0] b);
    logic [KEY_W-1:0] k;
    case (b)
      3'd0:    k = 8'd17;
      3'd1:    k = 8'd18;
      3'd2:    k = 8'd20;
      3'd3:    k = 8'd19;
      3'd4:    k = 8'd10;
      3'd5:    k = 8'd27;
      default: k = 8'd0;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/bdc_ifs.sv @@
// Channel interfaces: scan input, result output and register write port.
interface bdc_scan_if;
  logic                          valid;
  logic                          ready;
  logic [bdc_pkg::NOW_W-1:0]     now_ms;
  logic [bdc_pkg::LEVEL_W-1:0]   button_levels;

  modport source (output valid, now_ms, button_levels, input ready);
  modport sink   (input valid, now_ms, button_levels, output ready);
endinterface

interface bdc_result_if;
  logic                          valid;
  logic                          ready;
  logic [bdc_pkg::BTN_IDX_W-1:0] button_index;
  logic [bdc_pkg::EVENT_W-1:0]   event_code;
  logic [bdc_pkg::SLOT_W-1:0]    combo_slot;
  logic [bdc_pkg::KEY_W-1:0]     key_code;
  logic [bdc_pkg::LEVEL_W-1:0]   pressed_mask;
  logic                          first_pressed_valid;
  logic [bdc_pkg::KEY_W-1:0]     first_pressed_key;
  logic                          last_of_scan;

  modport source (output valid, button_index, event_code, combo_slot, key_code, pressed_mask,
                  first_pressed_valid, first_pressed_key, last_of_scan, input ready);
  modport sink   (input valid, button_index, event_code, combo_slot, key_code, pressed_mask,
                  first_pressed_valid, first_pressed_key, last_of_scan, output ready);
endinterface

interface bdc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bdc_pkg::CFG_ADDR_W-1:0] index;
  logic [bdc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bdc_cfg_regs.sv @@
// Configuration register file, always ready for a write transfer.
module bdc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_valid,
  input  logic [bdc_pkg::CFG_ADDR_W-1:0] wr_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0] wr_data,
  output logic                           wr_ready,
  output bdc_pkg::cfg_t                  cfg
);

  bdc_pkg::cfg_t cfg_r, cfg_nxt;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (bdc_pkg::cfg_reg_t'(wr_index))
        bdc_pkg::REG_DEBOUNCE:   cfg_nxt.settle_ms        = wr_data[bdc_pkg::MS_W-1:0];
        bdc_pkg::REG_WINDOW:     cfg_nxt.combo_window_ms  = wr_data[bdc_pkg::MS_W-1:0];
        bdc_pkg::REG_COUNT:      cfg_nxt.combo_count      = wr_data[bdc_pkg::COUNT_W-1:0];
        bdc_pkg::REG_PAIR0:      cfg_nxt.combo_pair[0]    = wr_data[bdc_pkg::PAIR_W-1:0];
        bdc_pkg::REG_PAIR1:      cfg_nxt.combo_pair[1]    = wr_data[bdc_pkg::PAIR_W-1:0];
        bdc_pkg::REG_PAIR2:      cfg_nxt.combo_pair[2]    = wr_data[bdc_pkg::PAIR_W-1:0];
        bdc_pkg::REG_PAIR3:      cfg_nxt.combo_pair[3]    = wr_data[bdc_pkg::PAIR_W-1:0];
        bdc_pkg::REG_KEY_ENABLE: cfg_nxt.key_event_enable = wr_data[0];
        default:                 cfg_nxt = cfg_r;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms        <= bdc_pkg::DEBOUNCE_RST;
      cfg_r.combo_window_ms  <= bdc_pkg::WINDOW_RST;
      cfg_r.combo_count      <= bdc_pkg::COUNT_RST;
      cfg_r.combo_pair       <= '0;
      cfg_r.key_event_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/bdc_ctrl.sv @@
// Sequencer: takes a scan, steps through the buttons, manages the result register valid.
module bdc_ctrl #(
  parameter int NUM_BUTTONS = bdc_pkg::NUM_BUTTONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bdc_pkg::dp_cmd_t cmd
);

  localparam logic [bdc_pkg::BTN_IDX_W-1:0] LAST_IDX = bdc_pkg::BTN_IDX_W'(NUM_BUTTONS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                        state_r, state_nxt;
  logic [bdc_pkg::BTN_IDX_W-1:0] idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load      = 1'b0;
    cmd.step      = 1'b0;
    cmd.idx       = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd.step      = 1'b1;
          out_valid_nxt = 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/bdc_datapath.sv @@
// Datapath: scan latch, per-button debounce/combo state, one button step per command, result register.
module bdc_datapath #(
  parameter int NUM_BUTTONS = bdc_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = bdc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bdc_pkg::cfg_t                 cfg,
  input  bdc_pkg::dp_cmd_t              cmd,
  input  logic [bdc_pkg::NOW_W-1:0]     now_ms,
  input  logic [bdc_pkg::LEVEL_W-1:0]   button_levels,
  output logic [bdc_pkg::BTN_IDX_W-1:0] button_index,
  output logic [bdc_pkg::EVENT_W-1:0]   event_code,
  output logic [bdc_pkg::SLOT_W-1:0]    combo_slot,
  output logic [bdc_pkg::KEY_W-1:0]     key_code,
  output logic [bdc_pkg::LEVEL_W-1:0]   pressed_mask,
  output logic                          first_pressed_valid,
  output logic [bdc_pkg::KEY_W-1:0]     first_pressed_key,
  output logic                          last_of_scan
);

  localparam int IDX_W = $clog2(NUM_BUTTONS);
  localparam int RB_W  = $clog2(NUM_BUTTONS + 1);
  localparam logic [RB_W-1:0] NO_BUTTON = RB_W'(NUM_BUTTONS);
  localparam logic [bdc_pkg::COUNT_W-1:0] COMBO_SAT = bdc_pkg::COUNT_W'(bdc_pkg::COMBO_LIM);
  localparam int CMP_W = 4;  // wide enough for any button number and "none"

  // scan latch
  logic [TIME_BITS-1:0]         now_r;
  logic [bdc_pkg::LEVEL_W-1:0]  levels_r;

  // button state
  logic [NUM_BUTTONS-1:0] accepted_r, accepted_nxt;
  logic [NUM_BUTTONS-1:0] pressed_r, pressed_nxt;
  logic [TIME_BITS-1:0]   change_time_r [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   change_time_nxt [NUM_BUTTONS];
  logic [RB_W-1:0]        recent_r, recent_nxt;
  logic [TIME_BITS-1:0]   recent_time_r, recent_time_nxt;

  // result register
  logic [bdc_pkg::BTN_IDX_W-1:0] index_r;
  bdc_pkg::event_t               event_r, event_nxt;
  logic [bdc_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [bdc_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [bdc_pkg::LEVEL_W-1:0]   mask_r, mask_nxt;
  logic                          fvalid_r, fvalid_nxt;
  logic [bdc_pkg::KEY_W-1:0]     fkey_r, fkey_nxt;
  logic                          last_r;

  logic [IDX_W-1:0]              idx;
  logic [bdc_pkg::NUM_IDX-1:0]   levels_ext;
  logic [bdc_pkg::NUM_IDX-1:0]   pressed_ext;
  logic                          cur;
  logic [TIME_BITS-1:0]          db_diff, win_diff;
  logic                          db_ok, win_ok;
  logic [bdc_pkg::COUNT_W-1:0]   ncombo;
  logic                          hit;
  logic [bdc_pkg::SLOT_W-1:0]    hit_slot;
  logic [bdc_pkg::KEY_W-1:0]     kc;

  assign idx        = cmd.idx[IDX_W-1:0];
  assign levels_ext = bdc_pkg::NUM_IDX'(levels_r);
  assign cur        = ~levels_ext[cmd.idx];  // active-low pins; absent pins read as pressed
  assign ncombo     = (cfg.combo_count > COMBO_SAT) ? COMBO_SAT : cfg.combo_count;

  assign db_diff  = now_r - change_time_r[idx];
  assign win_diff = now_r - recent_time_r;
  assign db_ok    = db_diff >= TIME_BITS'(cfg.settle_ms);
  assign win_ok   = (recent_r != NO_BUTTON) && (win_diff < TIME_BITS'(cfg.combo_window_ms));
  assign kc       = bdc_pkg::key_of(cmd.idx);

  // first active pair matching (recent, this) in either order
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int j = 0; j < bdc_pkg::NUM_PAIRS; j++) begin
      if (!hit && (bdc_pkg::COUNT_W'(j) < ncombo) &&
          (((CMP_W'(cfg.combo_pair[j][2:0]) == CMP_W'(recent_r)) &&
            (CMP_W'(cfg.combo_pair[j][5:3]) == CMP_W'(cmd.idx))) ||
           ((CMP_W'(cfg.combo_pair[j][2:0]) == CMP_W'(cmd.idx)) &&
            (CMP_W'(cfg.combo_pair[j][5:3]) == CMP_W'(recent_r))))) begin
        hit      = 1'b1;
        hit_slot = bdc_pkg::SLOT_W'(j);
      end
    end
  end

  always_comb begin
    accepted_nxt    = accepted_r;
    pressed_nxt     = pressed_r;
    change_time_nxt = change_time_r;
    recent_nxt      = recent_r;
    recent_time_nxt = recent_time_r;
    event_nxt       = bdc_pkg::EV_NONE;
    slot_nxt        = '0;
    key_nxt         = '0;
    if ((cur != accepted_r[idx]) && db_ok) begin
      accepted_nxt[idx]    = cur;
      change_time_nxt[idx] = now_r;
      if (cur && !pressed_r[idx]) begin
        pressed_nxt[idx] = 1'b1;
        event_nxt        = bdc_pkg::EV_PRESS;
        if (win_ok && hit) begin
          event_nxt        = bdc_pkg::EV_COMBO;
          slot_nxt         = hit_slot;
          pressed_nxt[idx] = 1'b0;
          if (recent_r < NO_BUTTON) begin
            pressed_nxt[recent_r[IDX_W-1:0]] = 1'b0;
          end
        end
        recent_nxt      = RB_W'(idx);
        recent_time_nxt = now_r;
      end else if (!cur && pressed_r[idx]) begin
        pressed_nxt[idx] = 1'b0;
        event_nxt        = bdc_pkg::EV_RELEASE;
        if (cfg.key_event_enable && (recent_r == RB_W'(idx))) begin
          if (kc != '0) begin
            event_nxt = bdc_pkg::EV_KEY;
            key_nxt   = kc;
          end
          recent_nxt = NO_BUTTON;
        end
      end
    end
  end

  // pressed summary after this step
  assign pressed_ext = bdc_pkg::NUM_IDX'(pressed_nxt);
  assign mask_nxt    = pressed_ext[bdc_pkg::LEVEL_W-1:0];

  always_comb begin
    fvalid_nxt = 1'b0;
    fkey_nxt   = '0;
    for (int j = NUM_BUTTONS - 1; j >= 0; j--) begin
      if (pressed_nxt[j]) begin
        fvalid_nxt = 1'b1;
        fkey_nxt   = bdc_pkg::key_of(bdc_pkg::BTN_IDX_W'(j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_r    <= '0;
      pressed_r     <= '0;
      recent_r      <= NO_BUTTON;
      recent_time_r <= '0;
      for (int j = 0; j < NUM_BUTTONS; j++) begin
        change_time_r[j] <= '0;
      end
    end else if (cmd.step) begin
      accepted_r    <= accepted_nxt;
      pressed_r     <= pressed_nxt;
      recent_r      <= recent_nxt;
      recent_time_r <= recent_time_nxt;
      change_time_r <= change_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r    <= now_ms[TIME_BITS-1:0];
      levels_r <= button_levels;
    end
    if (cmd.step) begin
      index_r  <= cmd.idx;
      event_r  <= event_nxt;
      slot_r   <= slot_nxt;
      key_r    <= key_nxt;
      mask_r   <= mask_nxt;
      fvalid_r <= fvalid_nxt;
      fkey_r   <= fkey_nxt;
      last_r   <= (cmd.idx == bdc_pkg::BTN_IDX_W'(NUM_BUTTONS - 1));
    end
  end

  assign button_index        = index_r;
  assign event_code          = event_r;
  assign combo_slot          = slot_r;
  assign key_code            = key_r;
  assign pressed_mask        = mask_r;
  assign first_pressed_valid = fvalid_r;
  assign first_pressed_key   = fkey_r;
  assign last_of_scan        = last_r;

endmodule

@@ rtl/button_debounce_combo_detector.sv @@
// Top level of the button debounce and combo detector.
//
//  channel   dir  modport  payload
//  in_scan   in   sink     now_ms[31:0], button_levels[5:0]
//  out_res   out  source   button_index, event_code, combo_slot, key_code,
//                          pressed_mask, first_pressed_valid, first_pressed_key, last_of_scan
//  cfg_wr    in   sink     index[3:0], data[15:0]
//
// A scan is latched first, then each button is stepped in turn through the
// shared step datapath, which is sequenced by the controller's button counter.
// The result register sits between the two sides; a new scan is taken while the last
// result of the previous one still waits. While the output stalls, stepping waits.
// Reset is synchronous, active low; it clears button, sequencer and config register state.
// cfg_wr is always ready; writes to unknown indexes are dropped.
module button_debounce_combo_detector #(
  parameter int NUM_BUTTONS = bdc_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = bdc_pkg::TIME_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  bdc_scan_if.sink    in_scan,
  bdc_result_if.source out_res,
  bdc_cfg_if.sink     cfg_wr
);

  bdc_pkg::cfg_t    cfg;
  bdc_pkg::dp_cmd_t cmd;

  // register file: a write transfer is registered
  bdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_wr.valid),
    .wr_index (cfg_wr.index),
    .wr_data  (cfg_wr.data),
    .wr_ready (cfg_wr.ready),
    .cfg      (cfg)
  );

  // sequencer: owns the handshakes and the button counter
  bdc_ctrl #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_scan.valid),
    .in_ready  (in_scan.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .cmd       (cmd)
  );

  // step datapath: debounce, combo match, key events, result payload
  bdc_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .now_ms              (in_scan.now_ms),
    .button_levels       (in_scan.button_levels),
    .button_index        (out_res.button_index),
    .event_code          (out_res.event_code),
    .combo_slot          (out_res.combo_slot),
    .key_code            (out_res.key_code),
    .pressed_mask        (out_res.pressed_mask),
    .first_pressed_valid (out_res.first_pressed_valid),
    .first_pressed_key   (out_res.first_pressed_key),
    .last_of_scan        (out_res.last_of_scan)
  );

endmodule
